>>> rtl/frp_pkg.sv
`default_nettype none

package frp_pkg;

	// Canvas geometry; BLOCK_STEP is a power of two so block math is shifts
	localparam int CANVAS_PIXELS = 256;
	localparam int BLOCK_STEP    = 4;
	localparam int STEP_SH       = $clog2(BLOCK_STEP);
	localparam int NBLK          = CANVAS_PIXELS / BLOCK_STEP;
	localparam int ROW_W         = $clog2(NBLK);
	localparam int CNT_W         = $clog2(NBLK + 1);

	// Fixed field widths
	localparam int DIM_W  = 9;
	localparam int POS_W  = 8;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	localparam logic [DIM_W-1:0] ACTIVE_RESET = DIM_W'(4);

	// Register index, taken from the word address
	typedef enum logic [0:0] {
		CFG_ACTIVE_WIDTH  = 1'b0,
		CFG_ACTIVE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		KIND_PLACE = 1'b0,
		KIND_CLEAR = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ENCODE,
		ST_MARK_RD,
		ST_MARK_WR
	} state_t;

	// Active size in blocks: clamp to canvas, drop partial block
	function automatic logic [CNT_W-1:0] usable_blocks(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] c;
		begin
			c = (v > DIM_W'(CANVAS_PIXELS)) ? DIM_W'(CANVAS_PIXELS) : v;
			return CNT_W'(c >> STEP_SH);
		end
	endfunction

endpackage

`default_nettype wire

>>> rtl/first_fit_rect_placer.sv
`default_nettype none

// First-fit rectangle placer over a 64x64 block occupancy map (4x4-pixel blocks).
// Command channel: an item (kind, rect_width, rect_height) transfers on a rising
// edge with start high and busy low. busy stays high until the result is issued.
// Result channel: done pulses for one cycle with placed, pos_x, pos_y valid; the
// receiver must take it then, there is no back-pressure.
// Config: APB port, active_width at 0x0, active_height at 0x4; write only while idle.
// Sequence: clear, rejected size and zero-area rectangle finish straight from idle
//   (clear empties the map at once). place: one map row per cycle through a
//   one-stage read pipeline until a fit is found or the last active row
//   (active_height/4 - 1) is scanned; when placed, an encode state follows, then
//   a map read state and a map write state per marked block row.
// One item is in flight at a time.
// The search uses 64 column run counters fed by a per-row window check.
// Reset: map reads empty (row valid bits cleared), sizes back to 4, idle.
// Marking is a read-modify-write through the map's one read port and one write port.

module first_fit_rect_placer (
	input  wire                               clk,
	input  wire                               arst_n,
	// command
	input  wire                               start,
	output logic                              busy,
	input  wire                               kind,
	input  wire  [frp_pkg::DIM_W-1:0]         rect_width,
	input  wire  [frp_pkg::DIM_W-1:0]         rect_height,
	// result
	output logic                              done,
	output logic                              placed,
	output logic [frp_pkg::POS_W-1:0]         pos_x,
	output logic [frp_pkg::POS_W-1:0]         pos_y,
	// configuration
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [frp_pkg::CFG_AW-1:0]        paddr,
	input  wire  [frp_pkg::CFG_DW-1:0]        pwdata,
	output logic [frp_pkg::CFG_DW-1:0]        prdata,
	output logic                              pready
);

	localparam int NBLK  = frp_pkg::NBLK;
	localparam int ROW_W = frp_pkg::ROW_W;
	localparam int CNT_W = frp_pkg::CNT_W;
	localparam int DIM_W = frp_pkg::DIM_W;
	localparam int POS_W = frp_pkg::POS_W;

	// Config registers
	logic [DIM_W-1:0] act_w_q, act_h_q;
	logic             cfg_wr;

	// Control
	frp_pkg::state_t  state_q, state_d;
	logic             take, fin, fin_placed, go_scan, mem_we, clr_map;

	// Item registers
	logic [CNT_W-1:0] bw_q, bh_q, chb_q;
	logic [NBLK-1:0]  colmask_q;

	// Map storage
	logic [NBLK-1:0]  map_mem [NBLK];
	logic [NBLK-1:0]  row_vld_q;
	logic [ROW_W-1:0] rd_addr;
	logic [NBLK-1:0]  rd_data_s1;
	logic             rd_vld_s1;
	logic [NBLK-1:0]  row_s1;
	logic [NBLK-1:0]  wr_data;

	// Scan
	logic [CNT_W-1:0] rd_row_q;
	logic             rd_en, scan_v_s1, last_row;
	logic [ROW_W-1:0] r_s1;
	logic [CNT_W-1:0] cnt_q    [NBLK];
	logic [CNT_W-1:0] cnt_next [NBLK];
	logic [NBLK-1:0]  free_v, hfit, pw, hit, hit_q;
	logic [CNT_W-1:0] off;
	logic [ROW_W-1:0] hrow_q;

	// Mark
	logic [ROW_W-1:0] mark_row_q;
	logic [CNT_W-1:0] mark_left_q;
	logic [NBLK-1:0]  mask_q;
	logic [ROW_W-1:0] bx_c;

	// Item decode
	logic [CNT_W-1:0] cwb_c, chb_c, bw_c, bh_c;
	logic             size_ok, zero_sz;

	// Result registers
	logic             done_q, placed_q;
	logic [POS_W-1:0] pos_x_q, pos_y_q;

	// Lowest set bit of a row vector
	function automatic logic [ROW_W-1:0] first_set(input logic [NBLK-1:0] v);
		logic [ROW_W-1:0] idx;
		begin
			idx = '0;
			for (int i = NBLK - 1; i >= 0; i--) begin
				if (v[i]) idx = ROW_W'(i);
			end
			return idx;
		end
	endfunction

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_w_q <= frp_pkg::ACTIVE_RESET;
			act_h_q <= frp_pkg::ACTIVE_RESET;
		end else if (cfg_wr) begin
			unique case (frp_pkg::cfg_reg_t'(paddr[2]))
				frp_pkg::CFG_ACTIVE_WIDTH:  act_w_q <= pwdata[DIM_W-1:0];
				frp_pkg::CFG_ACTIVE_HEIGHT: act_h_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (frp_pkg::cfg_reg_t'(paddr[2]))
			frp_pkg::CFG_ACTIVE_WIDTH:  prdata = frp_pkg::CFG_DW'(act_w_q);
			frp_pkg::CFG_ACTIVE_HEIGHT: prdata = frp_pkg::CFG_DW'(act_h_q);
			default:                    prdata = '0;
		endcase
	end

	// ---------------- item decode ----------------
	assign busy = (state_q != frp_pkg::ST_IDLE);
	assign take = start && !busy;

	always_comb begin
		cwb_c   = frp_pkg::usable_blocks(act_w_q);
		chb_c   = frp_pkg::usable_blocks(act_h_q);
		size_ok = ({1'b0, rect_width}  <= ((DIM_W+1)'(cwb_c) << frp_pkg::STEP_SH)) &&
		          ({1'b0, rect_height} <= ((DIM_W+1)'(chb_c) << frp_pkg::STEP_SH));
		bw_c    = CNT_W'(((DIM_W+1)'(rect_width)  + (DIM_W+1)'(frp_pkg::BLOCK_STEP - 1))
		                 >> frp_pkg::STEP_SH);
		bh_c    = CNT_W'(((DIM_W+1)'(rect_height) + (DIM_W+1)'(frp_pkg::BLOCK_STEP - 1))
		                 >> frp_pkg::STEP_SH);
		zero_sz = (rect_width == '0) || (rect_height == '0);
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= frp_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		fin        = 1'b0;
		fin_placed = 1'b0;
		go_scan    = 1'b0;
		mem_we     = 1'b0;
		clr_map    = 1'b0;
		unique case (state_q)
			frp_pkg::ST_IDLE: begin
				if (take) begin
					if (kind == frp_pkg::KIND_CLEAR) begin
						clr_map = 1'b1;
						fin     = 1'b1;
					end else if (!size_ok) begin
						fin = 1'b1;
					end else if (zero_sz) begin
						fin        = 1'b1;
						fin_placed = 1'b1;
					end else begin
						go_scan = 1'b1;
						state_d = frp_pkg::ST_SCAN;
					end
				end
			end
			frp_pkg::ST_SCAN: begin
				if (scan_v_s1) begin
					if (|hit) begin
						state_d = frp_pkg::ST_ENCODE;
					end else if (last_row) begin
						fin     = 1'b1;
						state_d = frp_pkg::ST_IDLE;
					end
				end
			end
			frp_pkg::ST_ENCODE:  state_d = frp_pkg::ST_MARK_RD;
			frp_pkg::ST_MARK_RD: state_d = frp_pkg::ST_MARK_WR;
			frp_pkg::ST_MARK_WR: begin
				mem_we = 1'b1;
				if (mark_left_q == CNT_W'(1)) begin
					fin        = 1'b1;
					fin_placed = 1'b1;
					state_d    = frp_pkg::ST_IDLE;
				end else begin
					state_d = frp_pkg::ST_MARK_RD;
				end
			end
			default: state_d = frp_pkg::ST_IDLE;
		endcase
	end

	// Latch item geometry
	always_ff @(posedge clk) begin
		if (take) begin
			bw_q  <= bw_c;
			bh_q  <= bh_c;
			chb_q <= chb_c;
			for (int i = 0; i < NBLK; i++) begin
				colmask_q[i] <= (CNT_W'(i) < cwb_c);
			end
		end
	end

	// ---------------- map memory ----------------
	assign rd_addr = (state_q == frp_pkg::ST_MARK_RD) ? mark_row_q : rd_row_q[ROW_W-1:0];
	assign row_s1  = rd_vld_s1 ? rd_data_s1 : '0;
	assign wr_data = row_s1 | mask_q;

	always_ff @(posedge clk) begin
		if (mem_we) map_mem[mark_row_q] <= wr_data;
		rd_data_s1 <= map_mem[rd_addr];
		rd_vld_s1  <= row_vld_q[rd_addr];
	end

	// Row valid bits: an invalid row reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)      row_vld_q <= '0;
		else if (clr_map) row_vld_q <= '0;
		else if (mem_we)  row_vld_q[mark_row_q] <= 1'b1;
	end

	// ---------------- row scan ----------------
	assign rd_en    = (state_q == frp_pkg::ST_SCAN) && (rd_row_q < chb_q);
	assign last_row = (CNT_W'(r_s1) == chb_q - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_v_s1 <= 1'b0;
			rd_row_q  <= '0;
		end else begin
			scan_v_s1 <= rd_en;
			if (go_scan)    rd_row_q <= '0;
			else if (rd_en) rd_row_q <= rd_row_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		r_s1 <= rd_row_q[ROW_W-1:0];
	end

	// Window check: column i fits if blocks i .. i+bw-1 of this row are free,
	// built from power-of-two windows picked by the bits of bw
	always_comb begin
		free_v = ~row_s1 & colmask_q;
		pw     = free_v;
		hfit   = '1;
		off    = '0;
		for (int k = 0; k < CNT_W; k++) begin
			if (bw_q[k]) begin
				hfit = hfit & (pw >> off);
				off  = off + CNT_W'(1 << k);
			end
			pw = pw & (pw >> (1 << k));
		end
	end

	// Per-column run of consecutive fitting rows; a run of bh rows is a hit
	always_comb begin
		for (int i = 0; i < NBLK; i++) begin
			cnt_next[i] = hfit[i] ? (cnt_q[i] + CNT_W'(1)) : '0;
			hit[i]      = (cnt_next[i] >= bh_q);
		end
	end

	always_ff @(posedge clk) begin
		if (go_scan) begin
			for (int i = 0; i < NBLK; i++) cnt_q[i] <= '0;
		end else if (state_q == frp_pkg::ST_SCAN && scan_v_s1) begin
			for (int i = 0; i < NBLK; i++) cnt_q[i] <= cnt_next[i];
		end
		if (state_q == frp_pkg::ST_SCAN) begin
			hit_q  <= hit;
			hrow_q <= ROW_W'(CNT_W'(r_s1) + CNT_W'(1) - bh_q);
		end
	end

	// ---------------- encode and mark ----------------
	assign bx_c = first_set(hit_q);

	always_ff @(posedge clk) begin
		if (state_q == frp_pkg::ST_ENCODE) begin
			mark_row_q  <= hrow_q;
			mark_left_q <= bh_q;
			mask_q      <= NBLK'((((NBLK+1)'(1) << bw_q) - (NBLK+1)'(1)) << bx_c);
		end else if (mem_we) begin
			mark_row_q  <= mark_row_q + ROW_W'(1);
			mark_left_q <= mark_left_q - CNT_W'(1);
		end
	end

	// ---------------- result ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			placed_q <= 1'b0;
		end else begin
			done_q   <= fin;
			placed_q <= fin_placed;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == frp_pkg::ST_ENCODE) begin
			pos_x_q <= POS_W'(bx_c) << frp_pkg::STEP_SH;
			pos_y_q <= POS_W'(hrow_q) << frp_pkg::STEP_SH;
		end else if (fin && state_q != frp_pkg::ST_MARK_WR) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
		end
	end

	assign done   = done_q;
	assign placed = placed_q;
	assign pos_x  = pos_x_q;
	assign pos_y  = pos_y_q;

	// ---------------- assertions ----------------
	a_take_resp: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (busy || done))
		else $error("accepted command produced neither busy nor a result");

	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_noplace_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !placed) |-> (pos_x == '0 && pos_y == '0))
		else $error("not-placed result carries a position");

	a_pos_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(done && placed) |->
			((pos_x & POS_W'(frp_pkg::BLOCK_STEP - 1)) == '0 &&
			 (pos_y & POS_W'(frp_pkg::BLOCK_STEP - 1)) == '0))
		else $error("placement not on a block corner");

endmodule

`default_nettype wire
